### rtl/spl_pkg.sv
package spl_pkg;

  localparam int KEY_W = 32;
  localparam int ID_W  = 16;

  typedef enum logic [2:0] {
    CMD_SORTED = 3'd0,
    CMD_HEAD   = 3'd1,
    CMD_TAIL   = 3'd2,
    CMD_POP    = 3'd3,
    CMD_REMOVE = 3'd4
  } cmd_t;

  typedef struct packed {
    logic load_new;
    logic take_prev;
    logic take_next;
  } cell_ctrl_t;

endpackage

### rtl/sorted_priority_list_core.sv
// Bounded list of (id, key) entries in a row of DEPTH cells that each hold one
// entry and shift it to a neighbour; sorted inserts keep largest key first, head
// and tail inserts go to the ends. In the accept cycle all cells compare their
// entry against the incoming key and id at once and the boundary bits are
// registered; when the output is free, a log-depth prefix over those bits tells
// each cell whether to hold, shift or load the new entry, and the result word
// is registered. A new word is taken only once the last has moved its cells;
// a stalled result holds the move. Entry cells have no reset; only positions
// below the entry count are ever read. No clearing pass is needed after reset.
module sorted_priority_list_core #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_command,
  input  logic [spl_pkg::ID_W-1:0]      in_entry_id,
  input  logic [spl_pkg::KEY_W-1:0]     in_entry_key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [spl_pkg::ID_W-1:0]      out_id,
  output logic [spl_pkg::KEY_W-1:0]     out_key,
  output logic                          out_overflow,
  output logic [$clog2(DEPTH+1)-1:0]    out_entry_count
);
  import spl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [KEY_W-1:0] cell_key [DEPTH];
  logic [ID_W-1:0]  cell_id  [DEPTH];
  logic [DEPTH-1:0] cell_ge, cell_hit, cell_valid;
  cell_ctrl_t       cell_ctrl [DEPTH];

  logic             busy_r, busy_nxt;
  cmd_t             cmd_r;
  logic [ID_W-1:0]  nid_r;
  logic [KEY_W-1:0] nkey_r;
  logic [DEPTH-1:0] sel_r, sel_nxt;
  logic             head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             found_r, found_nxt;
  logic [ID_W-1:0]  oid_r, oid_nxt;
  logic [KEY_W-1:0] okey_r, okey_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CW-1:0]    ocount_r, ocount_nxt;

  logic             accept, go, is_ins, is_rem, full, rem_hit, do_ins, do_rem;
  logic [DEPTH-1:0] excl, incl, pick, ins_mask;
  cmd_t             in_cmd;

  assign in_cmd = cmd_t'(in_command);
  assign accept = in_valid && !busy_r;
  assign go     = busy_r && !(out_valid_r && out_stall);

  // row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int PI = (g == 0) ? 0 : g - 1;
    localparam int NI = (g == DEPTH - 1) ? DEPTH - 1 : g + 1;
    spl_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl[g]),
      .prev_key (cell_key[PI]),
      .prev_id  (cell_id[PI]),
      .next_key (cell_key[NI]),
      .next_id  (cell_id[NI]),
      .new_key  (nkey_r),
      .new_id   (nid_r),
      .cmp_key  (in_entry_key),
      .cmp_id   (in_entry_id),
      .key_q    (cell_key[g]),
      .id_q     (cell_id[g]),
      .ge       (cell_ge[g]),
      .id_hit   (cell_hit[g])
    );
  end

  // first cycle: boundary bits from the parallel compare
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_valid[i] = count_r > CW'(i);
    end
    sel_nxt  = '0;
    head_nxt = 1'b0;
    case (in_cmd)
      CMD_SORTED: begin
        head_nxt = (count_r == '0) || ($signed(cell_key[0]) <= $signed(in_entry_key));
        for (int i = 0; i < DEPTH; i++) begin
          if (i == DEPTH - 1) begin
            sel_nxt[i] = cell_ge[i] && cell_valid[i];
          end else begin
            sel_nxt[i] = cell_ge[i] && cell_valid[i] && !(cell_valid[i+1] && cell_ge[i+1]);
          end
        end
      end
      CMD_HEAD: begin
        head_nxt = 1'b1;
      end
      CMD_TAIL: begin
        head_nxt = (count_r == '0);
        for (int i = 0; i < DEPTH; i++) begin
          if (i == DEPTH - 1) begin
            sel_nxt[i] = cell_valid[i];
          end else begin
            sel_nxt[i] = cell_valid[i] && !cell_valid[i+1];
          end
        end
      end
      CMD_POP: begin
        sel_nxt[0] = cell_valid[0];
      end
      CMD_REMOVE: begin
        sel_nxt = cell_valid & cell_hit;
      end
      default: begin
        sel_nxt = '0;
      end
    endcase
  end

  spl_prefix #(.N(DEPTH)) u_prefix (
    .sel  (sel_r),
    .excl (excl)
  );

  // after accept, once the output is free: cell moves and result word
  always_comb begin
    incl     = excl | sel_r;
    pick     = sel_r & ~excl;
    ins_mask = {DEPTH{head_r}} | excl;
    is_ins   = cmd_r inside {CMD_SORTED, CMD_HEAD, CMD_TAIL};
    is_rem   = cmd_r inside {CMD_POP, CMD_REMOVE};
    full     = (count_r == CW'(DEPTH));
    rem_hit  = |sel_r;
    do_ins   = go && is_ins && !full;
    do_rem   = go && is_rem && rem_hit;

    for (int i = 0; i < DEPTH; i++) begin
      cell_ctrl[i] = '0;
      if (do_ins && ins_mask[i]) begin
        if (i > 0 && ins_mask[(i > 0) ? i - 1 : 0]) begin
          cell_ctrl[i].take_prev = 1'b1;
        end else begin
          cell_ctrl[i].load_new = 1'b1;
        end
      end else if (do_rem && incl[i] && i < DEPTH - 1) begin
        cell_ctrl[i].take_next = 1'b1;
      end
    end

    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rem) begin
      count_nxt = count_r - 1'b1;
    end

    oid_nxt  = '0;
    okey_nxt = '0;
    if (is_rem) begin
      for (int i = 0; i < DEPTH; i++) begin
        oid_nxt  = oid_nxt  | (cell_id[i]  & {ID_W{pick[i]}});
        okey_nxt = okey_nxt | (cell_key[i] & {KEY_W{pick[i]}});
      end
    end
    found_nxt  = is_rem && rem_hit;
    ovf_nxt    = is_ins && full;
    ocount_nxt = count_nxt;

    if (go) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end

    if (accept) begin
      busy_nxt = 1'b1;
    end else begin
      busy_nxt = busy_r && !go;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_cmd;
      nid_r  <= in_entry_id;
      nkey_r <= in_entry_key;
      sel_r  <= sel_nxt;
      head_r <= head_nxt;
    end
    if (go) begin
      found_r  <= found_nxt;
      oid_r    <= oid_nxt;
      okey_r   <= okey_nxt;
      ovf_r    <= ovf_nxt;
      ocount_r <= ocount_nxt;
    end
  end

  assign in_stall        = busy_r;
  assign out_valid       = out_valid_r;
  assign out_found       = found_r;
  assign out_id          = oid_r;
  assign out_key         = okey_r;
  assign out_overflow    = ovf_r;
  assign out_entry_count = ocount_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_pick_single: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> $onehot0(pick))
    else $error("more than one entry picked");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_rem |=> (count_r == $past(count_r) - 1'b1))
    else $error("count not decremented on removal");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ovf_r) |-> (ocount_r == CW'(DEPTH)))
    else $error("overflow reported while not full");

endmodule

### rtl/spl_cell.sv
module spl_cell (
  input  logic                     clk,
  input  spl_pkg::cell_ctrl_t      ctrl,
  input  logic [spl_pkg::KEY_W-1:0] prev_key,
  input  logic [spl_pkg::ID_W-1:0]  prev_id,
  input  logic [spl_pkg::KEY_W-1:0] next_key,
  input  logic [spl_pkg::ID_W-1:0]  next_id,
  input  logic [spl_pkg::KEY_W-1:0] new_key,
  input  logic [spl_pkg::ID_W-1:0]  new_id,
  input  logic [spl_pkg::KEY_W-1:0] cmp_key,
  input  logic [spl_pkg::ID_W-1:0]  cmp_id,
  output logic [spl_pkg::KEY_W-1:0] key_q,
  output logic [spl_pkg::ID_W-1:0]  id_q,
  output logic                     ge,
  output logic                     id_hit
);
  import spl_pkg::*;

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;

  // shift from a neighbour or take the new entry
  always_comb begin
    key_nxt = key_r;
    id_nxt  = id_r;
    if (ctrl.take_prev) begin
      key_nxt = prev_key;
      id_nxt  = prev_id;
    end else if (ctrl.take_next) begin
      key_nxt = next_key;
      id_nxt  = next_id;
    end else if (ctrl.load_new) begin
      key_nxt = new_key;
      id_nxt  = new_id;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    id_r  <= id_nxt;
  end

  assign key_q  = key_r;
  assign id_q   = id_r;
  assign ge     = $signed(key_r) >= $signed(cmp_key);
  assign id_hit = (id_r == cmp_id);

endmodule

### rtl/spl_prefix.sv
module spl_prefix #(
  parameter int N = 64
) (
  input  logic [N-1:0] sel,
  output logic [N-1:0] excl
);
  import spl_pkg::*;

  localparam int L = $clog2(N);

  logic [N-1:0] lvl [L+1];

  // log-depth prefix or, exclusive of the own bit
  always_comb begin
    lvl[0] = sel;
    for (int s = 0; s < L; s++) begin
      for (int k = 0; k < N; k++) begin
        if (k >= (1 << s)) begin
          lvl[s+1][k] = lvl[s][k] | lvl[s][k - (1 << s)];
        end else begin
          lvl[s+1][k] = lvl[s][k];
        end
      end
    end
    excl = {lvl[L][N-2:0], 1'b0};
  end

endmodule

### bench/sorted_priority_list_checker.sv
`timescale 1ns / 1ps

module sorted_priority_list_checker #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [2:0]                 in_command,
  input  logic [spl_pkg::ID_W-1:0]   in_entry_id,
  input  logic [spl_pkg::KEY_W-1:0]  in_entry_key,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_found,
  input  logic [spl_pkg::ID_W-1:0]   out_id,
  input  logic [spl_pkg::KEY_W-1:0]  out_key,
  input  logic                       out_overflow,
  input  logic [$clog2(DEPTH+1)-1:0] out_entry_count,
  output int                         fail_count,
  output int                         pending
);
  import spl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] id;
    logic [KEY_W-1:0] key;
    logic            overflow;
    logic [CW-1:0]   entry_count;
  } result_word_t;

  logic signed [KEY_W-1:0] list_key [DEPTH];
  logic [ID_W-1:0]         list_id  [DEPTH];
  int                      list_len = 0;
  result_word_t            expected_words [$];
  int                      errors = 0;

  function automatic int sorted_slot(logic signed [KEY_W-1:0] v);
    if (list_len == 0 || v >= list_key[0]) return 0;
    for (int i = 0; i + 1 < list_len; i++) begin
      if (list_key[i] >= v && list_key[i+1] < v) return i + 1;
    end
    if (list_key[list_len-1] >= v) return list_len;
    return list_len - 1;
  endfunction

  function automatic result_word_t take_entry(int slot);
    result_word_t res;
    res = '0;
    res.found = 1'b1;
    res.id = list_id[slot];
    res.key = list_key[slot];
    for (int i = slot; i + 1 < list_len; i++) begin
      list_key[i] = list_key[i+1];
      list_id[i] = list_id[i+1];
    end
    list_len--;
    return res;
  endfunction

  function automatic result_word_t apply_command(logic [2:0] cmd, logic [ID_W-1:0] id,
                                                 logic signed [KEY_W-1:0] key);
    result_word_t res;
    int slot;
    res = '0;
    slot = 0;
    case (cmd)
      CMD_SORTED, CMD_HEAD, CMD_TAIL: begin
        if (list_len >= DEPTH) begin
          res.overflow = 1'b1;
        end else begin
          if (cmd == CMD_SORTED) slot = sorted_slot(key);
          else if (cmd == CMD_TAIL) slot = list_len;
          for (int i = list_len; i > slot; i--) begin
            list_key[i] = list_key[i-1];
            list_id[i] = list_id[i-1];
          end
          list_key[slot] = key;
          list_id[slot] = id;
          list_len++;
        end
      end
      CMD_POP: begin
        if (list_len > 0) res = take_entry(0);
      end
      CMD_REMOVE: begin
        for (int i = 0; i < list_len; i++) begin
          if (list_id[i] == id) begin
            res = take_entry(i);
            break;
          end
        end
      end
      default: ;
    endcase
    res.entry_count = CW'(list_len);
    return res;
  endfunction

  task automatic check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_word_t seen;
    result_word_t want;
    if (!rst_n) begin
      list_len = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = '{out_found, out_id, out_key, out_overflow, out_entry_count};
        if (expected_words.size() == 0) begin
          $display("%0t unexpected word expected none got %h", $time, seen);
          errors++;
        end else begin
          want = expected_words.pop_front();
          check_field("found", KEY_W'(want.found), KEY_W'(seen.found));
          check_field("id", KEY_W'(want.id), KEY_W'(seen.id));
          check_field("key", want.key, seen.key);
          check_field("overflow", KEY_W'(want.overflow), KEY_W'(seen.overflow));
          check_field("entry_count", KEY_W'(want.entry_count), KEY_W'(seen.entry_count));
        end
      end
      if (in_valid && !in_stall) begin
        expected_words.push_back(apply_command(in_command, in_entry_id, in_entry_key));
      end
    end
    fail_count <= errors;
    pending <= expected_words.size();
  end

endmodule

### bench/sorted_priority_list_core_tb.sv
`timescale 1ns / 1ps

module sorted_priority_list_core_tb;
  import spl_pkg::*;

  localparam int DEPTH = 64;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_PCT = 14;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [2:0]        in_command;
  logic [ID_W-1:0]   in_entry_id;
  logic [KEY_W-1:0]  in_entry_key;
  logic              out_valid;
  logic              out_stall;
  logic              out_found;
  logic [ID_W-1:0]   out_id;
  logic [KEY_W-1:0]  out_key;
  logic              out_overflow;
  logic [CW-1:0]     out_entry_count;
  int                fail_count;
  int                pending;
  int                idle_cycles = 0;
  bit                calm = 1'b0;

  sorted_priority_list_core #(.DEPTH(DEPTH)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_entry_id     (in_entry_id),
    .in_entry_key    (in_entry_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_id          (out_id),
    .out_key         (out_key),
    .out_overflow    (out_overflow),
    .out_entry_count (out_entry_count)
  );

  sorted_priority_list_checker #(.DEPTH(DEPTH)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_entry_id     (in_entry_id),
    .in_entry_key    (in_entry_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_id          (out_id),
    .out_key         (out_key),
    .out_overflow    (out_overflow),
    .out_entry_count (out_entry_count),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= rst_n && !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sorted_priority_list_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(logic [2:0] cmd, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_entry_id <= id;
    in_entry_key <= key;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // insert_pct steers the fill level: high fills to overflow, low empties the list
  task automatic random_phase(int words, int insert_pct);
    logic [2:0]       cmd;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    int               pick;
    repeat (words) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) cmd = 3'(CMD_REMOVE) + 3'($urandom_range(1, 3));
      else if (pick < insert_pct) begin
        pick = $urandom_range(0, 9);
        cmd = (pick < 6) ? CMD_SORTED : (pick < 8) ? CMD_HEAD : CMD_TAIL;
      end else cmd = $urandom_range(0, 1) ? CMD_POP : CMD_REMOVE;
      id = ($urandom_range(0, 9) < 7) ? ID_W'($urandom_range(0, 15)) : ID_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        case ($urandom_range(0, 3))
          0: key = 32'h7fff_ffff;
          1: key = 32'h8000_0000;
          2: key = 32'h0000_0000;
          default: key = 32'hffff_ffff;
        endcase
      end else if (pick < 50) key = {16'($urandom_range(0, 7)) - 16'd4, 16'h0000};
      else key = $urandom;
      send_word(cmd, id, key);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= CMD_POP;
    in_entry_id <= '0;
    in_entry_key <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(CMD_POP, 16'h0000, 32'h0000_0000);
    send_word(CMD_REMOVE, 16'hffff, 32'h0000_0000);
    send_word(CMD_SORTED, 16'h0000, 32'h0000_0000);
    send_word(CMD_SORTED, 16'hffff, 32'h7fff_ffff);
    send_word(CMD_SORTED, 16'h0001, 32'h8000_0000);
    send_word(CMD_SORTED, 16'h0002, 32'h0000_0000);
    send_word(CMD_HEAD, 16'h0003, 32'h8000_0000);
    send_word(CMD_TAIL, 16'h0004, 32'h7fff_ffff);
    send_word(CMD_SORTED, 16'h0005, 32'h0001_0000);
    send_word(CMD_SORTED, 16'h0006, 32'hffff_ffff);
    send_word(CMD_REMOVE, 16'h1234, 32'h0000_0000);
    send_word(CMD_REMOVE, 16'h0000, 32'h0000_0000);
    send_word(3'(CMD_REMOVE) + 3'd1, 16'h0000, 32'h0000_0000);
    send_word(3'(CMD_REMOVE) + 3'd2, 16'h5555, 32'haaaa_aaaa);
    send_word(3'(CMD_REMOVE) + 3'd3, 16'hffff, 32'hffff_ffff);
    send_word(CMD_REMOVE, 16'h0004, 32'h0000_0000);
    repeat (7) send_word(CMD_POP, 16'h0000, 32'h0000_0000);
    drain_results();

    // fill past capacity so every insert kind meets a full list
    random_phase(160, 80);
    drain_results();
    calm <= 1'b1;
    random_phase(130, 20);
    drain_results();
    calm <= 1'b0;
    random_phase(240, 50);

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sorted_priority_list_core: match");
    end else begin
      $display("sorted_priority_list_core: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
rtl/spl_pkg.sv
rtl/spl_cell.sv
rtl/spl_prefix.sv
rtl/sorted_priority_list_core.sv
bench/sorted_priority_list_checker.sv
bench/sorted_priority_list_core_tb.sv
